[rtl/dtq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the detection trigger qualifier
// Holds the configuration, input word, result word and state layouts.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TIME_BITS     = 32;
  localparam int RETRIGGER_MS  = 1500;
  localparam int KEEP_AWAKE_MS = 5000;

  localparam logic [15:0] W_NEW      = 16'd39322;
  localparam logic [15:0] W_OLD      = 16'd26214;
  localparam logic [15:0] ROUND_HALF = 16'd32768;
  localparam logic [7:0]  HITS_MAX   = 8'hFF;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_UNSURE = 2'd1,
    ACT_SURE   = 2'd2,
    ACT_DEACT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_AI_SURE   = 2'd0,
    MODE_AI_BOTH   = 2'd1,
    MODE_MO_UNSURE = 2'd2,
    MODE_MO_SURE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_TRIGGER_LEVEL = 3'd1,
    REG_RESET_LEVEL   = 3'd2,
    REG_WEAK_LEVEL    = 3'd3,
    REG_STRONG_LEVEL  = 3'd4,
    REG_REQUIRED_HITS = 3'd5,
    REG_COOLDOWN_MS   = 3'd6,
    REG_DEBOUNCE_MS   = 3'd7
  } reg_index_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] trigger_level;
    logic [15:0] reset_level;
    logic [15:0] weak_level;
    logic [15:0] strong_level;
    logic [7:0]  required_hits;
    logic [15:0] cooldown_ms;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    time_t       now;
    logic        motion_any;
    logic [15:0] probability;
    logic        busy;
  } item_t;

  typedef struct packed {
    logic [15:0] ema;
    logic [7:0]  hits;
    logic        alarm;
    time_t       last_change;
    time_t       last_fire;
    logic        fire_seen;
    time_t       high_start;
    logic        high_seen;
    logic        motion_latch;
    time_t       last_motion;
  } state_t;

  typedef struct packed {
    action_t     action;
    logic        alarm_active;
    logic [15:0] ema_level;
    logic [7:0]  hit_count;
    logic        in_cooldown;
    logic        motion_ok;
    logic        stay_awake;
    logic        dropped;
  } result_t;

endpackage

[rtl/dtq_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_step: one qualification step
// From the current state, configuration and one input word, forms the next
// state and the result word.
// ----------------------------------------------------------------------------
module dtq_step
  import dtq_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  always_comb begin
    logic        cool;
    logic        raw;
    logic        can_fire;
    logic        sure;
    logic        unsure;
    logic        dropped;
    logic        awake;
    logic [32:0] ema_sum;
    logic [16:0] ema_q;
    logic [15:0] ema_new;
    action_t     action;
    time_t       d_fire;

    st_nxt   = st;
    action   = ACT_NONE;
    dropped  = 1'b0;
    raw      = 1'b0;
    can_fire = 1'b0;
    sure     = 1'b0;
    unsure   = 1'b0;
    d_fire   = item.now - st.last_fire;
    cool     = st.fire_seen && (d_fire < time_t'(cfg.cooldown_ms));

    ema_sum = 33'(32'(W_NEW) * 32'(item.probability))
            + 33'(32'(W_OLD) * 32'(st.ema))
            + 33'(ROUND_HALF);
    ema_q   = ema_sum[32:16];
    ema_new = ema_q[16] ? 16'hFFFF : ema_q[15:0];

    if (!item.kind) begin
      // Motion is blanked while the deterrent cools down.
      raw = item.motion_any && !cool;
      if (raw) begin
        if (!st.high_seen) begin
          st_nxt.high_seen  = 1'b1;
          st_nxt.high_start = item.now;
        end else if ((time_t'(item.now - st.high_start) > time_t'(cfg.debounce_ms))
                     && !st.motion_latch) begin
          st_nxt.motion_latch = 1'b1;
          if (cfg.mode[1]) begin
            action             = (cfg.mode == MODE_MO_SURE) ? ACT_SURE : ACT_UNSURE;
            st_nxt.last_fire   = item.now;
            st_nxt.fire_seen   = 1'b1;
            st_nxt.alarm       = 1'b1;
          end
        end
      end else begin
        st_nxt.high_seen    = 1'b0;
        st_nxt.motion_latch = 1'b0;
      end
      if (st_nxt.motion_latch) begin
        st_nxt.last_motion = item.now;
      end
    end else if (cfg.mode[1] || cool) begin
      dropped = 1'b1;
    end else begin
      st_nxt.ema = ema_new;
      // The increment wins when both levels are met.
      if (ema_new >= cfg.trigger_level) begin
        if (st.hits != HITS_MAX) begin
          st_nxt.hits = st.hits + 8'd1;
        end
      end else if (ema_new <= cfg.reset_level) begin
        st_nxt.hits = '0;
        if (st.alarm) begin
          st_nxt.alarm       = 1'b0;
          st_nxt.last_change = item.now;
        end
      end
      can_fire = !st_nxt.alarm && (st_nxt.hits >= cfg.required_hits)
              && (time_t'(item.now - st_nxt.last_change) > time_t'(RETRIGGER_MS));
      sure   = ema_new >= cfg.strong_level;
      unsure = (cfg.mode == MODE_AI_BOTH) && (ema_new >= cfg.weak_level) && !sure;
      if (can_fire) begin
        if (sure || unsure) begin
          st_nxt.alarm       = 1'b1;
          st_nxt.last_change = item.now;
          st_nxt.last_fire   = item.now;
          st_nxt.fire_seen   = 1'b1;
          st_nxt.hits        = '0;
          action             = sure ? ACT_SURE : ACT_UNSURE;
        end
      end else if (!st_nxt.alarm) begin
        action = ACT_DEACT;
      end
    end

    awake = (time_t'(item.now - st_nxt.last_motion) < time_t'(KEEP_AWAKE_MS))
         || item.busy
         || (cool && (time_t'(item.now - st_nxt.last_fire) < time_t'(KEEP_AWAKE_MS)));

    res.action       = action;
    res.alarm_active = st_nxt.alarm;
    res.ema_level    = st_nxt.ema;
    res.hit_count    = st_nxt.hits;
    res.in_cooldown  = cool;
    res.motion_ok    = st_nxt.motion_latch;
    res.stay_awake   = awake;
    res.dropped      = dropped;
  end

endmodule

[rtl/detection_trigger_qualifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_trigger_qualifier: motion and classifier trigger qualification
// Debounces motion, smooths classifier probabilities and decides when the
// deterrent fires, with cooldown, retrigger delay and an alarm latch.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output side is not stalled and
// gives exactly one result word for each. A word is captured in the input
// register, passes through the single step stage (average update, hit
// counting and the firing decision) and lands in the result register while
// the state is updated at the same edge, so the next word already sees it.
// Configuration writes are taken in any cycle and must only be issued while
// no word is in flight.
module detection_trigger_qualifier
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_now_ms,
  input  logic        in_motion_left,
  input  logic        in_motion_center,
  input  logic        in_motion_right,
  input  logic [15:0] in_probability,
  input  logic        in_deterrent_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic        out_alarm_active,
  output logic [15:0] out_ema_level,
  output logic [7:0]  out_hit_count,
  output logic        out_in_cooldown,
  output logic        out_motion_ok,
  output logic        out_stay_awake,
  output logic        out_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.kind        <= in_kind;
      s1_item_r.now         <= time_t'(in_now_ms);
      s1_item_r.motion_any  <= in_motion_left | in_motion_center | in_motion_right;
      s1_item_r.probability <= in_probability;
      s1_item_r.busy        <= in_deterrent_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= MODE_MO_UNSURE;
      cfg_r.trigger_level <= 16'd26214;
      cfg_r.reset_level   <= 16'd16384;
      cfg_r.weak_level    <= 16'd39322;
      cfg_r.strong_level  <= 16'd49152;
      cfg_r.required_hits <= 8'd1;
      cfg_r.cooldown_ms   <= 16'd8000;
      cfg_r.debounce_ms   <= 16'd200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_MODE:          cfg_r.mode          <= mode_t'(cfg_data[1:0]);
        REG_TRIGGER_LEVEL: cfg_r.trigger_level <= cfg_data;
        REG_RESET_LEVEL:   cfg_r.reset_level   <= cfg_data;
        REG_WEAK_LEVEL:    cfg_r.weak_level    <= cfg_data;
        REG_STRONG_LEVEL:  cfg_r.strong_level  <= cfg_data;
        REG_REQUIRED_HITS: cfg_r.required_hits <= cfg_data[7:0];
        REG_COOLDOWN_MS:   cfg_r.cooldown_ms   <= cfg_data;
        REG_DEBOUNCE_MS:   cfg_r.debounce_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  dtq_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_res_r.action;
  assign out_alarm_active = out_res_r.alarm_active;
  assign out_ema_level    = out_res_r.ema_level;
  assign out_hit_count    = out_res_r.hit_count;
  assign out_in_cooldown  = out_res_r.in_cooldown;
  assign out_motion_ok    = out_res_r.motion_ok;
  assign out_stay_awake   = out_res_r.stay_awake;
  assign out_dropped      = out_res_r.dropped;

  // A word held in the input stage is never lost while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input stage word lost while stalled");

  // The state only moves when a word passes the step stage.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("state changed without a word");

  // A dropped sample never produces an action.
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.dropped |-> out_res_r.action == ACT_NONE)
    else $error("dropped sample carries an action");

  // Firing sets the alarm latch; deactivation only happens with it clear.
  a_fire_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.action == ACT_SURE || out_res_r.action == ACT_UNSURE)
    |-> out_res_r.alarm_active)
    else $error("firing without alarm latch");

  a_deact_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action == ACT_DEACT |-> !out_res_r.alarm_active)
    else $error("deactivate with alarm latched");

endmodule

[dv/detection_trigger_qualifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_trigger_qualifier_tb: self-checking bench for the trigger qualifier
// Feeds motion and probability words under a series of register settings,
// predicts every result word in software and compares it field by field.
// ----------------------------------------------------------------------------
module detection_trigger_qualifier_tb;
  import dtq_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic        left;
    logic        center;
    logic        right;
    logic [15:0] prob;
    logic        busy;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic        in_motion_left = 1'b0;
  logic        in_motion_center = 1'b0;
  logic        in_motion_right = 1'b0;
  logic [15:0] in_probability = '0;
  logic        in_deterrent_busy = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_action;
  logic        out_alarm_active;
  logic [15:0] out_ema_level;
  logic [7:0]  out_hit_count;
  logic        out_in_cooldown;
  logic        out_motion_ok;
  logic        out_stay_awake;
  logic        out_dropped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_index_t  cfg_index = REG_MODE;
  logic [15:0] cfg_data = '0;

  detection_trigger_qualifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_now_ms         (in_now_ms),
    .in_motion_left    (in_motion_left),
    .in_motion_center  (in_motion_center),
    .in_motion_right   (in_motion_right),
    .in_probability    (in_probability),
    .in_deterrent_busy (in_deterrent_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_alarm_active  (out_alarm_active),
    .out_ema_level     (out_ema_level),
    .out_hit_count     (out_hit_count),
    .out_in_cooldown   (out_in_cooldown),
    .out_motion_ok     (out_motion_ok),
    .out_stay_awake    (out_stay_awake),
    .out_dropped       (out_dropped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted register file and decision state.
  cfg_t        regs;
  logic [15:0] avg_q16 = '0;
  logic [7:0]  hit_ctr = '0;
  logic        alarm_on = 1'b0;
  logic        fired_once = 1'b0;
  logic        high_timed = 1'b0;
  logic        motion_held = 1'b0;
  logic [31:0] t_change = '0;
  logic [31:0] t_fire = '0;
  logic [31:0] t_high_start = '0;
  logic [31:0] t_motion = '0;

  sample_t pending_words[$];
  result_t expected_results[$];
  int      n_queued = 0;
  int      n_accepted = 0;
  int      n_errors = 0;
  int      n_results = 0;

  int tx_gap = 0;
  int tx_calm = 0;
  int rx_stall = 0;
  int rx_calm = 0;

  function automatic result_t qualify_step(input sample_t s);
    result_t     r;
    logic        raw;
    logic        cool;
    logic        can;
    logic        sure;
    logic        unsure;
    logic [33:0] acc;
    logic [15:0] e;
    r = '0;
    r.action = ACT_NONE;
    cool = fired_once && ((s.now - t_fire) < 32'(regs.cooldown_ms));
    if (!s.kind) begin
      raw = (s.left | s.center | s.right) && !cool;
      if (raw) begin
        if (!high_timed) begin
          high_timed = 1'b1;
          t_high_start = s.now;
        end else if (((s.now - t_high_start) > 32'(regs.debounce_ms)) && !motion_held) begin
          motion_held = 1'b1;
          if (regs.mode == MODE_MO_UNSURE || regs.mode == MODE_MO_SURE) begin
            r.action = (regs.mode == MODE_MO_SURE) ? ACT_SURE : ACT_UNSURE;
            t_fire = s.now;
            fired_once = 1'b1;
            alarm_on = 1'b1;
          end
        end
      end else begin
        high_timed = 1'b0;
        motion_held = 1'b0;
      end
      if (motion_held) t_motion = s.now;
    end else if (regs.mode == MODE_MO_UNSURE || regs.mode == MODE_MO_SURE || cool) begin
      r.dropped = 1'b1;
    end else begin
      acc = 34'(W_NEW) * 34'(s.prob) + 34'(W_OLD) * 34'(avg_q16) + 34'(ROUND_HALF);
      acc = acc >> 16;
      e = (acc > 34'h0FFFF) ? 16'hFFFF : acc[15:0];
      avg_q16 = e;
      // The increment takes priority when the two levels overlap.
      if (e >= regs.trigger_level) begin
        if (hit_ctr != HITS_MAX) hit_ctr = hit_ctr + 8'd1;
      end else if (e <= regs.reset_level) begin
        hit_ctr = '0;
        if (alarm_on) begin
          alarm_on = 1'b0;
          t_change = s.now;
        end
      end
      can = !alarm_on && (hit_ctr >= regs.required_hits) &&
            ((s.now - t_change) > 32'(RETRIGGER_MS));
      if (can) begin
        sure = e >= regs.strong_level;
        unsure = (regs.mode == MODE_AI_BOTH) && (e >= regs.weak_level) &&
                 (e < regs.strong_level);
        if (sure || unsure) begin
          alarm_on = 1'b1;
          t_change = s.now;
          t_fire = s.now;
          fired_once = 1'b1;
          hit_ctr = '0;
          r.action = sure ? ACT_SURE : ACT_UNSURE;
        end
      end else if (!alarm_on) begin
        r.action = ACT_DEACT;
      end
    end
    r.stay_awake = ((s.now - t_motion) < 32'(KEEP_AWAKE_MS)) || s.busy ||
                   (cool && ((s.now - t_fire) < 32'(KEEP_AWAKE_MS)));
    r.alarm_active = alarm_on;
    r.ema_level = avg_q16;
    r.hit_count = hit_ctr;
    r.in_cooldown = cool;
    r.motion_ok = motion_held;
    return r;
  endfunction

  // Wait length for one word, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("act=%0d alarm=%0d ema=%0d hits=%0d cool=%0d motion=%0d awake=%0d drop=%0d",
                     r.action, r.alarm_active, r.ema_level, r.hit_count, r.in_cooldown,
                     r.motion_ok, r.stay_awake, r.dropped);
  endfunction

  // Input driver: presents queued words, predicting each one as it is taken.
  sample_t cur_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(qualify_step(cur_word));
        n_accepted++;
        tx_gap = draw_wait(tx_calm);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_kind <= cur_word.kind;
          in_now_ms <= cur_word.now;
          in_motion_left <= cur_word.left;
          in_motion_center <= cur_word.center;
          in_motion_right <= cur_word.right;
          in_probability <= cur_word.prob;
          in_deterrent_busy <= cur_word.busy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.action = action_t'(out_action);
        got.alarm_active = out_alarm_active;
        got.ema_level = out_ema_level;
        got.hit_count = out_hit_count;
        got.in_cooldown = out_in_cooldown;
        got.motion_ok = out_motion_ok;
        got.stay_awake = out_stay_awake;
        got.dropped = out_dropped;
        if (expected_results.size() == 0) begin
          if (n_errors < 10) $display("result word %0d with none expected: %s", n_results,
                                      show(got));
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (n_errors < 10) begin
              $display("result word %0d mismatch", n_results);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            n_errors++;
          end
        end
        n_results++;
        rx_stall = draw_wait(rx_calm);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:          regs.mode = mode_t'(val[1:0]);
      REG_TRIGGER_LEVEL: regs.trigger_level = val;
      REG_RESET_LEVEL:   regs.reset_level = val;
      REG_WEAK_LEVEL:    regs.weak_level = val;
      REG_STRONG_LEVEL:  regs.strong_level = val;
      REG_REQUIRED_HITS: regs.required_hits = val[7:0];
      REG_COOLDOWN_MS:   regs.cooldown_ms = val;
      REG_DEBOUNCE_MS:   regs.debounce_ms = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_MODE, 16'(c.mode));
    write_reg(REG_TRIGGER_LEVEL, c.trigger_level);
    write_reg(REG_RESET_LEVEL, c.reset_level);
    write_reg(REG_WEAK_LEVEL, c.weak_level);
    write_reg(REG_STRONG_LEVEL, c.strong_level);
    write_reg(REG_REQUIRED_HITS, 16'(c.required_hits));
    write_reg(REG_COOLDOWN_MS, c.cooldown_ms);
    write_reg(REG_DEBOUNCE_MS, c.debounce_ms);
  endtask

  task automatic queue_word(input sample_t s);
    pending_words.push_back(s);
    n_queued++;
  endtask

  function automatic sample_t motion_word(input logic [31:0] t, input logic [2:0] sens,
                                          input logic busy);
    sample_t s;
    s = '0;
    s.now = t;
    {s.left, s.center, s.right} = sens;
    s.busy = busy;
    return s;
  endfunction

  function automatic sample_t prob_word(input logic [31:0] t, input logic [15:0] p,
                                        input logic busy);
    sample_t s;
    s = '0;
    s.kind = 1'b1;
    s.now = t;
    s.prob = p;
    s.busy = busy;
    return s;
  endfunction

  // Hold the sender until every word has been taken and every result checked.
  task automatic drain();
    while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  logic [31:0] t_ms;

  // One phase of random traffic: mostly timed motion bursts and probability
  // ramps that match the mode, with some fully random words mixed in.
  task automatic gen_phase(input int n_items);
    int      left;
    int      burst;
    int      i;
    int      sel;
    logic    seq_prob;
    logic    ai_mode;
    logic    high;
    sample_t s;
    left = n_items;
    ai_mode = (regs.mode == MODE_AI_SURE) || (regs.mode == MODE_AI_BOTH);
    while (left > 0) begin
      t_ms = t_ms + $urandom_range(0, regs.cooldown_ms + 6000);
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        s.kind = 1'($urandom);
        s.now = ($urandom_range(0, 7) == 0) ? $urandom : t_ms;
        {s.left, s.center, s.right} = 3'($urandom);
        s.prob = 16'($urandom);
        s.busy = 1'($urandom);
        queue_word(s);
        left--;
      end else begin
        burst = $urandom_range(2, 10);
        seq_prob = ai_mode ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0);
        for (i = 0; i < burst && left > 0; i++) begin
          high = (i < burst - 2) || ($urandom_range(0, 5) == 0);
          s.kind = seq_prob;
          s.busy = ($urandom_range(0, 5) == 0);
          if (!seq_prob) begin
            t_ms = t_ms + $urandom_range(0, regs.debounce_ms / 2 + 60);
            {s.left, s.center, s.right} = high ? 3'($urandom_range(1, 7)) : 3'b000;
            s.prob = 16'($urandom);
          end else begin
            t_ms = t_ms + $urandom_range(0, 900);
            s.prob = high ? 16'($urandom_range(30000, 65535)) : 16'($urandom_range(0, 20000));
            {s.left, s.center, s.right} = 3'($urandom);
          end
          s.now = t_ms;
          queue_word(s);
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    int   ph;
    regs.mode = MODE_MO_UNSURE;
    regs.trigger_level = 16'd26214;
    regs.reset_level = 16'd16384;
    regs.weak_level = 16'd39322;
    regs.strong_level = 16'd49152;
    regs.required_hits = 8'd1;
    regs.cooldown_ms = 16'd8000;
    regs.debounce_ms = 16'd200;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, motion unsure mode. Nothing has fired at time zero yet,
    // and the debounce must be exceeded strictly.
    queue_word(motion_word(32'd0, 3'b000, 1'b0));
    queue_word(prob_word(32'd10, 16'hFFFF, 1'b1));
    queue_word(motion_word(32'd1000, 3'b100, 1'b0));
    queue_word(motion_word(32'd1200, 3'b010, 1'b0));
    queue_word(motion_word(32'd1201, 3'b001, 1'b0));
    queue_word(motion_word(32'd2000, 3'b111, 1'b0));
    queue_word(prob_word(32'd2100, 16'd8000, 1'b0));
    queue_word(motion_word(32'd9201, 3'b100, 1'b0));
    drain();

    write_reg(REG_MODE, 16'(MODE_MO_SURE));
    write_reg(REG_DEBOUNCE_MS, 16'd0);
    write_reg(REG_COOLDOWN_MS, 16'd0);
    queue_word(motion_word(32'd20000, 3'b100, 1'b0));
    queue_word(motion_word(32'd20001, 3'b100, 1'b0));
    queue_word(motion_word(32'd20002, 3'b000, 1'b1));
    drain();

    // Sure and unsure classifier mode: clear, armed below band, sure fire,
    // dropped in cooldown, then an unsure fire; then motion across the wrap.
    write_reg(REG_MODE, 16'(MODE_AI_BOTH));
    write_reg(REG_DEBOUNCE_MS, 16'd200);
    write_reg(REG_COOLDOWN_MS, 16'd8000);
    queue_word(prob_word(32'd30000, 16'd0, 1'b0));
    queue_word(prob_word(32'd31600, 16'hFFFF, 1'b0));
    queue_word(prob_word(32'd31700, 16'hFFFF, 1'b0));
    queue_word(prob_word(32'd32000, 16'hFFFF, 1'b0));
    queue_word(prob_word(32'd40000, 16'd30000, 1'b0));
    queue_word(prob_word(32'd40100, 16'd0, 1'b0));
    queue_word(prob_word(32'd42000, 16'd50000, 1'b0));
    queue_word(prob_word(32'd42100, 16'd50000, 1'b0));
    queue_word(motion_word(32'hFFFF_FFFF, 3'b111, 1'b1));
    queue_word(motion_word(32'd100, 3'b111, 1'b0));
    queue_word(motion_word(32'd500, 3'b111, 1'b0));
    queue_word(prob_word(32'd600, 16'd0, 1'b0));
    drain();

    for (ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        // All registers zero: levels overlap, the alarm never clears and the
        // hit counter runs into saturation.
        c = '0;
        c.mode = MODE_AI_SURE;
      end else if (ph == 1) begin
        c.mode = MODE_MO_SURE;
        c.trigger_level = 16'hFFFF;
        c.reset_level = 16'hFFFF;
        c.weak_level = 16'hFFFF;
        c.strong_level = 16'hFFFF;
        c.required_hits = 8'hFF;
        c.cooldown_ms = 16'hFFFF;
        c.debounce_ms = 16'hFFFF;
      end else begin
        c.mode = mode_t'(ph % 4);
        c.reset_level = 16'($urandom_range(5000, 25000));
        c.trigger_level = c.reset_level + 16'($urandom_range(0, 15000));
        c.weak_level = 16'($urandom_range(25000, 45000));
        c.strong_level = c.weak_level + 16'($urandom_range(0, 20000));
        if ($urandom_range(0, 3) == 0) c.trigger_level = 16'($urandom);
        if ($urandom_range(0, 3) == 0) c.reset_level = 16'($urandom);
        if ($urandom_range(0, 3) == 0) c.weak_level = 16'($urandom);
        if ($urandom_range(0, 3) == 0) c.strong_level = 16'($urandom);
        c.required_hits = 8'($urandom_range(0, 4));
        c.cooldown_ms = 16'($urandom_range(0, 12000));
        c.debounce_ms = 16'($urandom_range(0, 600));
      end
      load_regs(c);
      t_ms = $urandom;
      gen_phase((ph == 0) ? 350 : (ph == 1) ? 120 : 140);
      drain();
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/dtq_pkg.sv
rtl/dtq_step.sv
rtl/detection_trigger_qualifier.sv
dv/detection_trigger_qualifier_tb.sv
